FILE: sv/rrss_pkg.sv
// ----------------------------------------------------------------------------
// rrss_pkg: shared types for the round robin sleep scheduler
// Slot states, command codes, slot table entry and controller commands.
// ----------------------------------------------------------------------------
package rrss_pkg;

  localparam int unsigned DEF_SLOT_COUNT = 16;

  typedef enum logic [2:0] {
    ST_UNUSED   = 3'd0,
    ST_READY    = 3'd1,
    ST_RUNNING  = 3'd2,
    ST_SLEEPING = 3'd3,
    ST_ZOMBIE   = 3'd4
  } st_e;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_YIELD  = 3'd1,
    CMD_SLEEP  = 3'd2,
    CMD_EXIT   = 3'd3,
    CMD_CREATE = 3'd4
  } cmd_e;

  // one slot table entry
  typedef struct packed {
    st_e         status;
    logic [31:0] ident;
    logic [63:0] wake;
  } ent_t;

  // controller to datapath
  typedef struct packed {
    logic start;       // item accepted this cycle
    logic cur_rd;      // read the current slot
    logic cur_pr;      // update the current slot from read data
    logic scan_rd;     // read the slot at the scan index
    logic scan_pr;     // process the slot read in the previous cycle
    logic commit_old;  // demote the old running slot
    logic commit_new;  // promote the picked slot
    logic finish;      // settle the result flags
  } ctrl_t;

endpackage

FILE: sv/rrss_ctrl.sv
// ----------------------------------------------------------------------------
// rrss_ctrl: scheduler sequencer
// Steps each command through the read, scan and commit phases it needs.
// ----------------------------------------------------------------------------
module rrss_ctrl import rrss_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT,
  localparam int unsigned IDX_W = $clog2(SLOT_COUNT),
  localparam int unsigned CNT_W = $clog2(SLOT_COUNT + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       cmd_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ctrl_t            ctrl_o,
  output logic [IDX_W-1:0] scan_idx_o
);

  localparam logic [CNT_W-1:0] LEN_ALL = CNT_W'(SLOT_COUNT);
  localparam logic [CNT_W-1:0] LEN_OTH = CNT_W'(SLOT_COUNT - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CUR_RD,
    S_CUR_PR,
    S_SCAN,
    S_OLD,
    S_NEW,
    S_DONE,
    S_OUT
  } state_e;

  state_e           state_q;
  logic [CNT_W-1:0] cnt_q;
  logic             rs_q;      // reschedule scan covers the other slots only
  logic [CNT_W-1:0] scan_len;
  logic             accept;

  assign scan_len   = rs_q ? LEN_OTH : LEN_ALL;
  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept     = in_valid_i && in_ready_o;
  assign scan_idx_o = cnt_q[IDX_W-1:0];

  always_comb begin
    ctrl_o            = '0;
    ctrl_o.start      = accept;
    ctrl_o.cur_rd     = (state_q == S_CUR_RD);
    ctrl_o.cur_pr     = (state_q == S_CUR_PR);
    ctrl_o.scan_rd    = (state_q == S_SCAN) && (cnt_q < scan_len);
    ctrl_o.scan_pr    = (state_q == S_SCAN) && (cnt_q != '0);
    ctrl_o.commit_old = (state_q == S_OLD);
    ctrl_o.commit_new = (state_q == S_NEW);
    ctrl_o.finish     = (state_q == S_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      rs_q    <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            cnt_q <= '0;
            unique case (cmd_i)
              CMD_TICK, CMD_CREATE: begin
                rs_q    <= 1'b0;
                state_q <= S_SCAN;
              end
              CMD_YIELD, CMD_SLEEP, CMD_EXIT: begin
                rs_q    <= 1'b1;
                state_q <= S_CUR_RD;
              end
              default: state_q <= S_DONE;
            endcase
          end
        end
        S_CUR_RD: state_q <= S_CUR_PR;
        S_CUR_PR: begin
          cnt_q   <= '0;
          state_q <= S_SCAN;
        end
        S_SCAN: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == scan_len) begin
            state_q <= rs_q ? S_OLD : S_DONE;
          end
        end
        S_OLD:  state_q <= S_NEW;
        S_NEW:  state_q <= S_DONE;
        S_DONE: state_q <= S_OUT;
        S_OUT: begin
          if (out_ready_i) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_one_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({ctrl_o.start, ctrl_o.cur_rd, ctrl_o.cur_pr, ctrl_o.scan_rd | ctrl_o.scan_pr,
              ctrl_o.commit_old, ctrl_o.commit_new, ctrl_o.finish}))
    else $error("more than one datapath phase active");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o && !out_valid_o)
    else $error("sequencer did not leave idle on accept");

endmodule

FILE: sv/rrss_datapath.sv
// ----------------------------------------------------------------------------
// rrss_datapath: slot table and scheduler registers
// Two port slot table with valid bits, tick and id counters, pick logic.
// ----------------------------------------------------------------------------
module rrss_datapath import rrss_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT,
  localparam int unsigned IDX_W = $clog2(SLOT_COUNT)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [2:0]       cmd_i,
  input  logic [31:0]      sleep_length_i,
  input  ctrl_t            ctrl_i,
  input  logic [IDX_W-1:0] scan_idx_i,
  output logic [3:0]       running_slot_o,
  output logic [31:0]      running_id_o,
  output logic             did_switch_o,
  output logic             create_status_o,
  output logic [31:0]      created_id_o
);

  localparam logic [IDX_W:0] SLOTS = (IDX_W + 1)'(SLOT_COUNT);

  // slot table
  ent_t                  mem_q [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] vld_q;
  ent_t                  rd_ent_q;
  logic                  rd_vld_q;
  logic [IDX_W-1:0]      rd_addr_q;

  // scheduler state
  logic [2:0]       cmd_q;
  logic [31:0]      len_q;
  logic [63:0]      tick_q;
  logic [31:0]      id_q;
  logic [IDX_W-1:0] cur_q;
  logic [31:0]      cur_id_q;
  ent_t             cur_ent_q;
  logic [IDX_W-1:0] pick_q;
  ent_t             pick_ent_q;
  logic             found_q;
  logic             sw_q;
  logic             full_q;
  logic [31:0]      made_q;

  logic             resched;
  logic [IDX_W:0]   addr_sum;
  logic [IDX_W-1:0] scan_addr;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  ent_t             rd_e;
  ent_t             cur_mod;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  ent_t             wr_ent;
  logic [IDX_W+3:0] slot_ext;

  assign resched = (cmd_q == CMD_YIELD) || (cmd_q == CMD_SLEEP) || (cmd_q == CMD_EXIT);

  // reschedule scans cur+1 .. cur+N-1, wrapping
  always_comb begin
    addr_sum = {1'b0, cur_q} + {1'b0, scan_idx_i} + 1'b1;
    if (addr_sum >= SLOTS) begin
      addr_sum = addr_sum - SLOTS;
    end
    scan_addr = resched ? addr_sum[IDX_W-1:0] : scan_idx_i;
  end

  assign rd_en   = ctrl_i.cur_rd || ctrl_i.scan_rd;
  assign rd_addr = ctrl_i.cur_rd ? cur_q : scan_addr;

  // entries never written read as their reset contents
  always_comb begin
    if (rd_vld_q) begin
      rd_e = rd_ent_q;
    end else begin
      rd_e = '{status: ST_UNUSED, ident: 32'd0, wake: 64'd0};
      if (rd_addr_q == IDX_W'(0)) begin
        rd_e.status = ST_RUNNING;
        rd_e.ident  = 32'd1;
      end else if (rd_addr_q == IDX_W'(1)) begin
        rd_e.status = ST_READY;
        rd_e.ident  = 32'd2;
      end
    end
  end

  always_comb begin
    cur_mod = rd_e;
    if ((cmd_q == CMD_SLEEP) && (len_q != '0)) begin
      cur_mod.status = ST_SLEEPING;
      cur_mod.wake   = tick_q + {32'd0, len_q};
    end else if (cmd_q == CMD_EXIT) begin
      cur_mod.status = ST_ZOMBIE;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rd_addr_q;
    wr_ent  = rd_e;
    priority if (ctrl_i.cur_pr) begin
      wr_en  = 1'b1;
      wr_ent = cur_mod;
    end else if (ctrl_i.scan_pr) begin
      unique case (cmd_q)
        CMD_TICK: begin
          if ((rd_e.status == ST_SLEEPING) && (tick_q >= rd_e.wake)) begin
            wr_en         = 1'b1;
            wr_ent.status = ST_READY;
            wr_ent.wake   = '0;
          end
        end
        CMD_YIELD, CMD_SLEEP, CMD_EXIT: begin
          if (rd_e.status == ST_ZOMBIE) begin
            wr_en  = 1'b1;
            wr_ent = '{status: ST_UNUSED, ident: 32'd0, wake: 64'd0};
          end
        end
        CMD_CREATE: begin
          if ((rd_e.status == ST_UNUSED) && !found_q) begin
            wr_en  = 1'b1;
            wr_ent = '{status: ST_READY, ident: id_q, wake: 64'd0};
          end
        end
        default: wr_en = 1'b0;
      endcase
    end else if (ctrl_i.commit_old) begin
      wr_en         = found_q && (cur_ent_q.status == ST_RUNNING);
      wr_addr       = cur_q;
      wr_ent        = cur_ent_q;
      wr_ent.status = ST_READY;
    end else if (ctrl_i.commit_new) begin
      wr_en         = found_q;
      wr_addr       = pick_q;
      wr_ent        = pick_ent_q;
      wr_ent.status = ST_RUNNING;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_ent;
    end
    if (rd_en) begin
      rd_ent_q  <= mem_q[rd_addr];
      rd_vld_q  <= vld_q[rd_addr];
      rd_addr_q <= rd_addr;
    end
    if (ctrl_i.start) begin
      len_q <= sleep_length_i;
    end
    if (ctrl_i.cur_pr) begin
      cur_ent_q <= cur_mod;
    end
    if (ctrl_i.scan_pr && resched && (rd_e.status == ST_READY) && !found_q) begin
      pick_q     <= rd_addr_q;
      pick_ent_q <= rd_e;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      cmd_q    <= CMD_TICK;
      tick_q   <= '0;
      id_q     <= 32'd3;
      cur_q    <= '0;
      cur_id_q <= 32'd1;
      found_q  <= 1'b0;
      sw_q     <= 1'b0;
      full_q   <= 1'b0;
      made_q   <= '0;
    end else begin
      if (wr_en) begin
        vld_q[wr_addr] <= 1'b1;
      end
      if (ctrl_i.start) begin
        cmd_q   <= cmd_i;
        found_q <= 1'b0;
        made_q  <= '0;
        if (cmd_i == CMD_TICK) begin
          tick_q <= tick_q + 64'd1;
        end
      end
      if (ctrl_i.scan_pr && !found_q) begin
        if (resched && (rd_e.status == ST_READY)) begin
          found_q <= 1'b1;
        end else if ((cmd_q == CMD_CREATE) && (rd_e.status == ST_UNUSED)) begin
          found_q <= 1'b1;
          made_q  <= id_q;
          id_q    <= id_q + 32'd1;
        end
      end
      if (ctrl_i.commit_new && found_q) begin
        cur_q    <= pick_q;
        cur_id_q <= pick_ent_q.ident;
      end
      if (ctrl_i.finish) begin
        sw_q   <= resched && found_q;
        full_q <= (cmd_q == CMD_CREATE) && !found_q;
      end
    end
  end

  assign slot_ext        = {4'd0, cur_q};
  assign running_slot_o  = slot_ext[3:0];
  assign running_id_o    = cur_id_q;
  assign did_switch_o    = sw_q;
  assign create_status_o = full_q;
  assign created_id_o    = made_q;

  a_no_port_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en && rd_en |-> wr_addr != rd_addr)
    else $error("slot table read and write hit the same entry");

  a_pick_differs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.commit_new && found_q |-> pick_q != cur_q)
    else $error("picked slot equals current slot");

  a_found_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.start |=> !found_q && (made_q == '0))
    else $error("per-item flags not cleared on accept");

endmodule

FILE: sv/round_robin_sleep_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler: slot table thread scheduler
// Tick, yield, sleep, exit and create over a round robin slot table.
//
//   channel | direction | beat contents
//   --------+-----------+------------------------------------------------------
//   in      | input     | cmd, sleep_length
//   out     | output    | running_slot, running_id, did_switch, create_status,
//           |           | created_id
//
// One beat in, one beat out, one item at a time.
// Tick and create scan all slots; yield/sleep/exit update the current slot,
// scan the other slots, then commit any switch; other codes go straight to
// the result. The scan reads one entry per cycle through its single read port.
// Reset: table contents come from per-entry valid bits, no clearing pass.
// A stalled out beat holds the block; in is not ready until it is taken.
// ----------------------------------------------------------------------------
module round_robin_sleep_scheduler import rrss_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] sleep_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  running_slot_o,
  output logic [31:0] running_id_o,
  output logic        did_switch_o,
  output logic        create_status_o,
  output logic [31:0] created_id_o
);

  localparam int unsigned IDX_W = $clog2(SLOT_COUNT);

  ctrl_t            ctrl;
  logic [IDX_W-1:0] scan_idx;

  rrss_ctrl #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_i      (cmd_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .ctrl_o     (ctrl),
    .scan_idx_o (scan_idx)
  );

  rrss_datapath #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd_i),
    .sleep_length_i (sleep_length_i),
    .ctrl_i         (ctrl),
    .scan_idx_i     (scan_idx),
    .running_slot_o (running_slot_o),
    .running_id_o   (running_id_o),
    .did_switch_o   (did_switch_o),
    .create_status_o(create_status_o),
    .created_id_o   (created_id_o)
  );

endmodule

FILE: tb/rrss_sched_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrss_sched_checker: scoreboard for the round robin sleep scheduler
// Watches the in and out channels. Keeps its own slot table, predicts each
// out beat from the accepted command and compares it field by field.
// ----------------------------------------------------------------------------
module rrss_sched_checker import rrss_pkg::*; #(
  parameter int unsigned SLOT_COUNT = DEF_SLOT_COUNT
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] sleep_length_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [3:0]  running_slot_i,
  input  logic [31:0] running_id_i,
  input  logic        did_switch_i,
  input  logic        create_status_i,
  input  logic [31:0] created_id_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct {
    logic [3:0]  slot;
    logic [31:0] ident;
    logic        switched;
    logic        full;
    logic [31:0] made;
  } sched_result_t;

  // shadow slot table
  st_e         slot_st   [SLOT_COUNT];
  logic [31:0] slot_id   [SLOT_COUNT];
  logic [63:0] slot_wake [SLOT_COUNT];
  int unsigned cur_slot;
  logic [31:0] next_id;
  logic [63:0] ticks;

  sched_result_t sched_expect_q[$];

  function automatic sched_result_t schedule_command(logic [2:0] c, logic [31:0] len);
    sched_result_t r;
    int unsigned   prev;
    int unsigned   pick;
    int unsigned   idx;
    logic          resched;
    logic          found;
    prev       = cur_slot;
    resched    = 1'b0;
    r.full     = 1'b0;
    r.made     = '0;
    case (c)
      CMD_TICK: begin
        ticks = ticks + 64'd1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (slot_st[i] == ST_SLEEPING && ticks >= slot_wake[i]) begin
            slot_st[i]   = ST_READY;
            slot_wake[i] = '0;
          end
        end
      end
      CMD_YIELD: resched = 1'b1;
      CMD_SLEEP: begin
        // zero length is a plain yield
        if (len != '0) begin
          slot_wake[cur_slot] = ticks + {32'd0, len};
          slot_st[cur_slot]   = ST_SLEEPING;
        end
        resched = 1'b1;
      end
      CMD_EXIT: begin
        slot_st[cur_slot] = ST_ZOMBIE;
        resched           = 1'b1;
      end
      CMD_CREATE: begin
        r.full = 1'b1;
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (r.full && slot_st[i] == ST_UNUSED) begin
            slot_st[i]   = ST_READY;
            slot_wake[i] = '0;
            slot_id[i]   = next_id;
            r.made       = next_id;
            next_id      = next_id + 32'd1;
            r.full       = 1'b0;
          end
        end
      end
      default: ;
    endcase
    if (resched) begin
      // the current slot is never reclaimed, even as a zombie
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (slot_st[i] == ST_ZOMBIE && i != cur_slot) begin
          slot_st[i]   = ST_UNUSED;
          slot_id[i]   = '0;
          slot_wake[i] = '0;
        end
      end
      pick  = cur_slot;
      found = 1'b0;
      for (int s = 1; s <= SLOT_COUNT; s++) begin
        idx = (cur_slot + s) % SLOT_COUNT;
        if (!found && slot_st[idx] == ST_READY) begin
          pick  = idx;
          found = 1'b1;
        end
      end
      if (pick != cur_slot) begin
        if (slot_st[cur_slot] == ST_RUNNING) slot_st[cur_slot] = ST_READY;
        slot_st[pick] = ST_RUNNING;
        cur_slot      = pick;
      end
    end
    r.slot     = cur_slot[3:0];
    r.ident    = slot_id[cur_slot];
    r.switched = (cur_slot != prev);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        slot_st[i]   = ST_UNUSED;
        slot_id[i]   = '0;
        slot_wake[i] = '0;
      end
      slot_st[0]   = ST_RUNNING;
      slot_id[0]   = 32'd1;
      slot_st[1]   = ST_READY;
      slot_id[1]   = 32'd2;
      cur_slot     = 0;
      next_id      = 32'd3;
      ticks        = '0;
      sched_expect_q.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        sched_expect_q.push_back(schedule_command(cmd_i, sleep_length_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (sched_expect_q.size() == 0) begin
          $error("out beat with no command pending");
          fail_count_o++;
        end else begin
          exp_r = sched_expect_q.pop_front();
          if (running_slot_i !== exp_r.slot) begin
            $error("running_slot: expected %0d, got %0d", exp_r.slot, running_slot_i);
            fail_count_o++;
          end
          if (running_id_i !== exp_r.ident) begin
            $error("running_id: expected %0h, got %0h", exp_r.ident, running_id_i);
            fail_count_o++;
          end
          if (did_switch_i !== exp_r.switched) begin
            $error("did_switch: expected %0b, got %0b", exp_r.switched, did_switch_i);
            fail_count_o++;
          end
          if (create_status_i !== exp_r.full) begin
            $error("create_status: expected %0b, got %0b", exp_r.full, create_status_i);
            fail_count_o++;
          end
          if (created_id_i !== exp_r.made) begin
            $error("created_id: expected %0h, got %0h", exp_r.made, created_id_i);
            fail_count_o++;
          end
        end
      end
      pending_o <= sched_expect_q.size();
    end
  end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the round robin sleep scheduler
// Directed command sequences (wake up, lone zombie, full table, unknown
// codes) then random traffic in three idle/stall profiles; the checker
// predicts and compares every out beat.
// ----------------------------------------------------------------------------
module tb_top import rrss_pkg::*; ();

  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_CYCLES  = 40;
  localparam int unsigned ITEMS_PER_PHASE = 420;
  localparam logic [2:0]  CMD_BAD_FIRST = 3'd5;
  localparam int unsigned BAD_CODES     = 3;
  localparam int unsigned SLOT_COUNT_FILL = DEF_SLOT_COUNT;

  logic        clk_i          = 1'b0;
  logic        rst_ni         = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [2:0]  cmd            = '0;
  logic [31:0] sleep_length   = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [3:0]  running_slot;
  logic [31:0] running_id;
  logic        did_switch;
  logic        create_status;
  logic [31:0] created_id;

  int          fail_count;
  int          pending;
  int unsigned gap_pct        = 10;
  int unsigned stall_pct      = 48;
  int unsigned cycle_count    = 0;

  always #1 clk_i = ~clk_i;

  round_robin_sleep_scheduler dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .cmd_i           (cmd),
    .sleep_length_i  (sleep_length),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .running_slot_o  (running_slot),
    .running_id_o    (running_id),
    .did_switch_o    (did_switch),
    .create_status_o (create_status),
    .created_id_o    (created_id)
  );

  rrss_sched_checker chk (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_ready_i      (in_ready),
    .cmd_i           (cmd),
    .sleep_length_i  (sleep_length),
    .out_valid_i     (out_valid),
    .out_ready_i     (out_ready),
    .running_slot_i  (running_slot),
    .running_id_i    (running_id),
    .did_switch_i    (did_switch),
    .create_status_i (create_status),
    .created_id_i    (created_id),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_cmd(input logic [2:0] c, input logic [31:0] len);
    if ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < gap_pct);
    end
    in_valid     <= 1'b1;
    cmd          <= c;
    sleep_length <= len;
    do @(posedge clk_i); while (!in_ready);
  endtask

  initial begin
    int unsigned sent;
    int unsigned pick;
    int unsigned lsel;
    logic [31:0] len;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // slot 0 sleeps, slot 1 exits with nothing ready and stays current
    send_cmd(CMD_YIELD, 32'hFFFF_FFFF);
    send_cmd(CMD_SLEEP, 32'd0);
    send_cmd(CMD_SLEEP, 32'd1);
    send_cmd(CMD_EXIT, $urandom());
    send_cmd(CMD_TICK, $urandom());
    send_cmd(CMD_YIELD, 32'd0);
    // zombie freed, no other thread ready
    send_cmd(CMD_YIELD, 32'd0);
    // fill the table, then one more create hits full
    repeat (SLOT_COUNT_FILL) send_cmd(CMD_CREATE, $urandom());
    send_cmd(CMD_SLEEP, 32'hFFFF_FFFF);
    for (int b = 0; b < BAD_CODES; b++) send_cmd(CMD_BAD_FIRST + 3'(b), $urandom());

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin gap_pct = 10; stall_pct = 48; end
        1: begin gap_pct = 48; stall_pct = 10; end
        default: begin gap_pct = 0; stall_pct = 0; end
      endcase
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        len  = $urandom();
        if (pick < 30) begin
          send_cmd(CMD_TICK, len);
        end else if (pick < 45) begin
          send_cmd(CMD_YIELD, len);
        end else if (pick < 65) begin
          // long sleeps park a slot for good, so keep them rare
          lsel = $urandom_range(99);
          if (lsel < 10) len = '0;
          else if (lsel < 99) len = $urandom_range(6, 1);
          send_cmd(CMD_SLEEP, len);
        end else if (pick < 77) begin
          send_cmd(CMD_EXIT, len);
        end else if (pick < 97) begin
          send_cmd(CMD_CREATE, len);
        end else begin
          send_cmd(CMD_BAD_FIRST + 3'($urandom_range(BAD_CODES - 1)), len);
          sent--;
        end
        sent++;
      end
    end
    in_valid <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
